// File: sv/rbcs_pkg.sv
// ---------------------------------------------------------------------------
// rbcs_pkg
// Shared codes and types of the block cache scheduler: request kinds,
// response status, slot phases and the slot update command.
// ---------------------------------------------------------------------------
package rbcs_pkg;

    // request kinds
    localparam logic [2:0] K_SCHED   = 3'd0;
    localparam logic [2:0] K_RELEASE = 3'd1;
    localparam logic [2:0] K_PICK    = 3'd2;
    localparam logic [2:0] K_DONE    = 3'd3;
    localparam logic [2:0] K_QUERY   = 3'd4;

    // response status
    localparam logic [2:0] ST_HIT     = 3'd0;
    localparam logic [2:0] ST_ALLOC   = 3'd1;
    localparam logic [2:0] ST_NOFREE  = 3'd2;
    localparam logic [2:0] ST_PICKED  = 3'd3;
    localparam logic [2:0] ST_NOSCHED = 3'd4;
    localparam logic [2:0] ST_OK      = 3'd5;
    localparam logic [2:0] ST_UNDER   = 3'd6;

    // slot phases
    localparam logic [1:0] PH_CLEAN = 2'd0;
    localparam logic [1:0] PH_SCHED = 2'd1;
    localparam logic [1:0] PH_DOWN  = 2'd2;
    localparam logic [1:0] PH_DONE  = 2'd3;

    // slot update operations
    typedef enum logic [2:0] {
        OP_NONE  = 3'd0,
        OP_HIT   = 3'd1,
        OP_ALLOC = 3'd2,
        OP_PICK  = 3'd3,
        OP_REL   = 3'd4,
        OP_FIN   = 3'd5
    } op_t;

    typedef struct packed {
        op_t  op;
        logic success;
    } upd_t;

endpackage

// File: sv/rbcs_cell.sv
// ---------------------------------------------------------------------------
// rbcs_cell
// One slot of the table. Holds the slot state, merges its own candidate
// into the search records handed on from the previous cell, and applies
// the update command when it is the target.
// ---------------------------------------------------------------------------
module rbcs_cell
    import rbcs_pkg::*;
#(
    parameter int IDX      = 0,
    parameter int IDX_W    = 5,
    parameter int BLK_W    = 10,
    parameter int REF_BITS = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    // broadcast request
    input  logic [31:0]         req_file,
    input  logic [31:0]         req_rev,
    input  logic [BLK_W-1:0]    req_blk,
    input  logic [31:0]         req_now,
    // update command
    input  upd_t                upd,
    input  logic [IDX_W-1:0]    upd_idx,
    // search records from the previous cell
    input  logic                hit_found_in,
    input  logic [IDX_W-1:0]    hit_idx_in,
    input  logic                free_found_in,
    input  logic [IDX_W-1:0]    free_idx_in,
    input  logic [31:0]         free_stamp_in,
    input  logic                pk_found_in,
    input  logic [IDX_W-1:0]    pk_idx_in,
    input  logic [REF_BITS-1:0] pk_refs_in,
    input  logic [BLK_W-1:0]    pk_blk_in,
    // search records to the next cell
    output logic                hit_found_out,
    output logic [IDX_W-1:0]    hit_idx_out,
    output logic                free_found_out,
    output logic [IDX_W-1:0]    free_idx_out,
    output logic [31:0]         free_stamp_out,
    output logic                pk_found_out,
    output logic [IDX_W-1:0]    pk_idx_out,
    output logic [REF_BITS-1:0] pk_refs_out,
    output logic [BLK_W-1:0]    pk_blk_out,
    // slot contents
    output logic [31:0]         file,
    output logic [31:0]         rev,
    output logic [BLK_W-1:0]    blk,
    output logic [1:0]          phase,
    output logic [REF_BITS-1:0] refs
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

    logic                valid_reg;
    logic [REF_BITS-1:0] refs_reg;
    logic [1:0]          phase_reg;
    logic [31:0]         stamp_reg;
    logic [31:0]         file_reg;
    logic [31:0]         rev_reg;
    logic [BLK_W-1:0]    blk_reg;

    logic                hit_found_reg, free_found_reg, pk_found_reg;
    logic [IDX_W-1:0]    hit_idx_reg, free_idx_reg, pk_idx_reg;
    logic [31:0]         free_stamp_reg;
    logic [REF_BITS-1:0] pk_refs_reg;
    logic [BLK_W-1:0]    pk_blk_reg;

    logic                match, take_free, take_pk, sel;
    logic [REF_BITS-1:0] refs_inc;

    // candidate tests
    always_comb
    begin
        match = valid_reg && file_reg == req_file && rev_reg == req_rev &&
                blk_reg == req_blk;
        take_free = (refs_reg == '0) &&
                    (!free_found_in || stamp_reg < free_stamp_in);
        take_pk = valid_reg && phase_reg == PH_SCHED &&
                  (!pk_found_in || refs_reg > pk_refs_in ||
                   (refs_reg == pk_refs_in && blk_reg < pk_blk_in));
        sel = (upd.op != OP_NONE) && (upd_idx == MY_IDX);
        refs_inc = (refs_reg == '1) ? refs_reg : refs_reg + 1'b1;
    end

    // search records, one hop per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_found_reg  <= 1'b0;
            free_found_reg <= 1'b0;
            pk_found_reg   <= 1'b0;
        end
        else
        begin
            hit_found_reg  <= hit_found_in | match;
            free_found_reg <= free_found_in | take_free;
            pk_found_reg   <= pk_found_in | take_pk;
        end
    end

    always_ff @(posedge clk)
    begin
        hit_idx_reg    <= hit_found_in ? hit_idx_in : MY_IDX;
        free_idx_reg   <= take_free ? MY_IDX : free_idx_in;
        free_stamp_reg <= take_free ? stamp_reg : free_stamp_in;
        pk_idx_reg     <= take_pk ? MY_IDX : pk_idx_in;
        pk_refs_reg    <= take_pk ? refs_reg : pk_refs_in;
        pk_blk_reg     <= take_pk ? blk_reg : pk_blk_in;
    end

    // slot control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            refs_reg  <= '0;
            phase_reg <= PH_CLEAN;
            stamp_reg <= '0;
        end
        else if (sel)
        begin
            case (upd.op)
                OP_HIT:
                begin
                    stamp_reg <= req_now;
                    refs_reg  <= refs_inc;
                end
                OP_ALLOC:
                begin
                    valid_reg <= 1'b1;
                    phase_reg <= PH_SCHED;
                    stamp_reg <= req_now;
                    refs_reg  <= REF_BITS'(1);
                end
                OP_PICK:
                begin
                    phase_reg <= PH_DOWN;
                    refs_reg  <= refs_inc;
                end
                OP_REL:
                begin
                    refs_reg <= refs_reg - 1'b1;
                end
                OP_FIN:
                begin
                    phase_reg <= upd.success ? PH_DONE : PH_SCHED;
                    refs_reg  <= refs_reg - 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    // slot tag, written on allocation
    always_ff @(posedge clk)
    begin
        if (sel && upd.op == OP_ALLOC)
        begin
            file_reg <= req_file;
            rev_reg  <= req_rev;
            blk_reg  <= req_blk;
        end
    end

    assign hit_found_out  = hit_found_reg;
    assign hit_idx_out    = hit_idx_reg;
    assign free_found_out = free_found_reg;
    assign free_idx_out   = free_idx_reg;
    assign free_stamp_out = free_stamp_reg;
    assign pk_found_out   = pk_found_reg;
    assign pk_idx_out     = pk_idx_reg;
    assign pk_refs_out    = pk_refs_reg;
    assign pk_blk_out     = pk_blk_reg;
    assign file  = file_reg;
    assign rev   = rev_reg;
    assign blk   = blk_reg;
    assign phase = phase_reg;
    assign refs  = refs_reg;

endmodule

// File: sv/refcounted_block_cache_scheduler.sv
// ---------------------------------------------------------------------------
// refcounted_block_cache_scheduler
// Fully associative slot table with reference counts. Lookup, victim and
// fetch selection run as search records passed along a row of slot cells.
// ---------------------------------------------------------------------------
//  channel   | handshake             | fields
//  request   | start, busy           | kind file_key revision_key byte_offset
//            |                       | slot success now
//  response  | done (one cycle)      | status slot_index block_number file_id
//            |                       | revision_id slot_state references
//
//  schedule and pick: the search records walk the row of SLOTS cells one hop
//  a cycle, followed by apply, read back and strobe.
//  release, fetch done and query: apply, read back, strobe.
//  busy is high from the accepting edge until the response is registered;
//  the response strobe is never held off. Reset clears all slot control state.
// ---------------------------------------------------------------------------
module refcounted_block_cache_scheduler
    import rbcs_pkg::*;
#(
    parameter int SLOTS       = 32,
    parameter int BLOCK_SHIFT = 22,
    parameter int REF_BITS    = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  kind,
    input  logic [31:0] file_key,
    input  logic [31:0] revision_key,
    input  logic [31:0] byte_offset,
    input  logic [4:0]  slot,
    input  logic        success,
    input  logic [31:0] now,
    output logic        done,
    output logic [2:0]  status,
    output logic [4:0]  slot_index,
    output logic [9:0]  block_number,
    output logic [31:0] file_id,
    output logic [31:0] revision_id,
    output logic [1:0]  slot_state,
    output logic [7:0]  references
);

    localparam int IDX_W = $clog2(SLOTS);
    localparam int BLK_W = 32 - BLOCK_SHIFT;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_APPLY = 4'b0100,
        S_RESP  = 4'b1000
    } state_t;

    state_t            state_reg, state_next;
    logic [IDX_W-1:0]  cnt_reg;
    logic [2:0]        kind_reg;
    logic [31:0]       file_reg, rev_reg, now_reg;
    logic [BLK_W-1:0]  blk_reg;
    logic [4:0]        slot_reg;
    logic              succ_reg;

    logic [2:0]        rstat_reg;
    logic [4:0]        ridx_out_reg;
    logic [IDX_W-1:0]  ridx_reg;
    logic              rlive_reg;

    logic              done_reg;
    logic [2:0]        status_reg;
    logic [4:0]        slot_index_reg;
    logic [9:0]        block_number_reg;
    logic [31:0]       file_id_reg, revision_id_reg;
    logic [1:0]        slot_state_reg;
    logic [7:0]        references_reg;

    // search chain, position 0 is the empty record
    logic                hit_f  [SLOTS+1];
    logic [IDX_W-1:0]    hit_i  [SLOTS+1];
    logic                free_f [SLOTS+1];
    logic [IDX_W-1:0]    free_i [SLOTS+1];
    logic [31:0]         free_s [SLOTS+1];
    logic                pk_f   [SLOTS+1];
    logic [IDX_W-1:0]    pk_i   [SLOTS+1];
    logic [REF_BITS-1:0] pk_r   [SLOTS+1];
    logic [BLK_W-1:0]    pk_b   [SLOTS+1];

    logic [31:0]         c_file  [SLOTS];
    logic [31:0]         c_rev   [SLOTS];
    logic [BLK_W-1:0]    c_blk   [SLOTS];
    logic [1:0]          c_phase [SLOTS];
    logic [REF_BITS-1:0] c_refs  [SLOTS];

    upd_t              upd;
    logic [IDX_W-1:0]  upd_idx;
    logic [2:0]        dstat;
    logic [4:0]        didx;
    logic              dlive;
    logic              in_range;
    logic [IDX_W-1:0]  s_idx;
    logic [31:0]       blk_ext, refs_ext;

    assign hit_f[0]  = 1'b0;
    assign hit_i[0]  = '0;
    assign free_f[0] = 1'b0;
    assign free_i[0] = '0;
    assign free_s[0] = '0;
    assign pk_f[0]   = 1'b0;
    assign pk_i[0]   = '0;
    assign pk_r[0]   = '0;
    assign pk_b[0]   = '0;

    // row of slot cells
    for (genvar g = 0; g < SLOTS; g++)
    begin : g_cell
        rbcs_cell #(
            .IDX      (g),
            .IDX_W    (IDX_W),
            .BLK_W    (BLK_W),
            .REF_BITS (REF_BITS)
        ) u_cell (
            .clk            (clk),
            .rst_n          (rst_n),
            .req_file       (file_reg),
            .req_rev        (rev_reg),
            .req_blk        (blk_reg),
            .req_now        (now_reg),
            .upd            (upd),
            .upd_idx        (upd_idx),
            .hit_found_in   (hit_f[g]),
            .hit_idx_in     (hit_i[g]),
            .free_found_in  (free_f[g]),
            .free_idx_in    (free_i[g]),
            .free_stamp_in  (free_s[g]),
            .pk_found_in    (pk_f[g]),
            .pk_idx_in      (pk_i[g]),
            .pk_refs_in     (pk_r[g]),
            .pk_blk_in      (pk_b[g]),
            .hit_found_out  (hit_f[g+1]),
            .hit_idx_out    (hit_i[g+1]),
            .free_found_out (free_f[g+1]),
            .free_idx_out   (free_i[g+1]),
            .free_stamp_out (free_s[g+1]),
            .pk_found_out   (pk_f[g+1]),
            .pk_idx_out     (pk_i[g+1]),
            .pk_refs_out    (pk_r[g+1]),
            .pk_blk_out     (pk_b[g+1]),
            .file           (c_file[g]),
            .rev            (c_rev[g]),
            .blk            (c_blk[g]),
            .phase          (c_phase[g]),
            .refs           (c_refs[g])
        );
    end

    assign busy = (state_reg != S_IDLE);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = (kind == K_SCHED || kind == K_PICK) ? S_SCAN : S_APPLY;
                end
            end
            S_SCAN:
            begin
                if (cnt_reg == IDX_W'(SLOTS - 1))
                begin
                    state_next = S_APPLY;
                end
            end
            S_APPLY: state_next = S_RESP;
            S_RESP:  state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // decision on the finished search or the addressed slot
    always_comb
    begin
        in_range = 32'(slot_reg) < SLOTS;
        s_idx    = IDX_W'(slot_reg);
        upd      = '{op: OP_NONE, success: succ_reg};
        upd_idx  = s_idx;
        dstat    = ST_OK;
        didx     = slot_reg;
        dlive    = in_range;
        if (state_reg == S_APPLY)
        begin
            case (kind_reg)
                K_SCHED:
                begin
                    if (hit_f[SLOTS])
                    begin
                        upd.op  = OP_HIT;
                        upd_idx = hit_i[SLOTS];
                        dstat   = ST_HIT;
                        didx    = 5'(hit_i[SLOTS]);
                        dlive   = 1'b1;
                    end
                    else if (free_f[SLOTS])
                    begin
                        upd.op  = OP_ALLOC;
                        upd_idx = free_i[SLOTS];
                        dstat   = ST_ALLOC;
                        didx    = 5'(free_i[SLOTS]);
                        dlive   = 1'b1;
                    end
                    else
                    begin
                        dstat = ST_NOFREE;
                        didx  = '0;
                        dlive = 1'b0;
                    end
                end
                K_PICK:
                begin
                    if (pk_f[SLOTS])
                    begin
                        upd.op  = OP_PICK;
                        upd_idx = pk_i[SLOTS];
                        dstat   = ST_PICKED;
                        didx    = 5'(pk_i[SLOTS]);
                        dlive   = 1'b1;
                    end
                    else
                    begin
                        dstat = ST_NOSCHED;
                        didx  = '0;
                        dlive = 1'b0;
                    end
                end
                K_RELEASE, K_DONE:
                begin
                    if (!in_range || c_refs[s_idx] == '0)
                    begin
                        dstat = ST_UNDER;
                    end
                    else
                    begin
                        upd.op = (kind_reg == K_DONE) ? OP_FIN : OP_REL;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // request capture and sequencing
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == S_RESP);
            if (state_reg == S_SCAN)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else
            begin
                cnt_reg <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && start)
        begin
            kind_reg <= kind;
            file_reg <= file_key;
            rev_reg  <= revision_key;
            blk_reg  <= BLK_W'(byte_offset >> BLOCK_SHIFT);
            slot_reg <= slot;
            succ_reg <= success;
            now_reg  <= now;
        end
        if (state_reg == S_APPLY)
        begin
            rstat_reg    <= dstat;
            ridx_out_reg <= didx;
            ridx_reg     <= upd_idx;
            rlive_reg    <= dlive;
        end
    end

    // read back the slot after the update
    always_comb
    begin
        blk_ext  = 32'(c_blk[ridx_reg]);
        refs_ext = 32'(c_refs[ridx_reg]);
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_RESP)
        begin
            status_reg     <= rstat_reg;
            slot_index_reg <= ridx_out_reg;
            if (rlive_reg)
            begin
                block_number_reg <= blk_ext[9:0];
                file_id_reg      <= c_file[ridx_reg];
                revision_id_reg  <= c_rev[ridx_reg];
                slot_state_reg   <= c_phase[ridx_reg];
                references_reg   <= refs_ext[7:0];
            end
            else
            begin
                block_number_reg <= '0;
                file_id_reg      <= '0;
                revision_id_reg  <= '0;
                slot_state_reg   <= '0;
                references_reg   <= '0;
            end
        end
    end

    assign done         = done_reg;
    assign status       = status_reg;
    assign slot_index   = slot_index_reg;
    assign block_number = block_number_reg;
    assign file_id      = file_id_reg;
    assign revision_id  = revision_id_reg;
    assign slot_state   = slot_state_reg;
    assign references   = references_reg;

endmodule

// File: tb/tb_refcounted_block_cache_scheduler.sv
// ---------------------------------------------------------------------------
// tb_refcounted_block_cache_scheduler
// Self-checking bench for the block cache scheduler. An initial block builds
// request transactions, predicts each response with a behavioral copy of
// the slot table and queues both; a clocked driver issues the requests with
// random gaps and a clocked monitor compares every response in order.
// ---------------------------------------------------------------------------
module tb_refcounted_block_cache_scheduler;
    timeunit 1ns;
    timeprecision 1ps;

    import rbcs_pkg::*;

    localparam int  NSLOT     = 32;
    localparam int  BSHIFT    = 22;
    localparam int  REF_TOP   = 255;
    localparam int  CYCLE_MAX = 2000000;

    typedef struct {
        logic [2:0]  kind;
        logic [31:0] fkey;
        logic [31:0] rkey;
        logic [31:0] boff;
        logic [4:0]  slot;
        logic        succ;
        logic [31:0] stamp;
    } request_t;

    typedef struct {
        logic [2:0]  status;
        logic [4:0]  idx;
        logic [9:0]  blk;
        logic [31:0] fid;
        logic [31:0] rid;
        logic [1:0]  phase;
        logic [7:0]  refs;
    } response_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [2:0]  kind;
    logic [31:0] file_key;
    logic [31:0] revision_key;
    logic [31:0] byte_offset;
    logic [4:0]  slot;
    logic        success;
    logic [31:0] now;
    logic        done;
    logic [2:0]  status;
    logic [4:0]  slot_index;
    logic [9:0]  block_number;
    logic [31:0] file_id;
    logic [31:0] revision_id;
    logic [1:0]  slot_state;
    logic [7:0]  references;

    // shadow slot table
    bit          tbl_valid [NSLOT];
    logic [31:0] tbl_file  [NSLOT];
    logic [31:0] tbl_rev   [NSLOT];
    logic [9:0]  tbl_blk   [NSLOT];
    int          tbl_refs  [NSLOT];
    logic [1:0]  tbl_phase [NSLOT];
    logic [31:0] tbl_stamp [NSLOT];

    request_t    pending_reqs [$];
    response_t   expected_rsps [$];
    int          idle_pct;
    int          errors;
    int          cycles;
    bit          took;
    logic [31:0] clock_now;
    logic [31:0] key_pool [4];

    refcounted_block_cache_scheduler u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .kind         (kind),
        .file_key     (file_key),
        .revision_key (revision_key),
        .byte_offset  (byte_offset),
        .slot         (slot),
        .success      (success),
        .now          (now),
        .done         (done),
        .status       (status),
        .slot_index   (slot_index),
        .block_number (block_number),
        .file_id      (file_id),
        .revision_id  (revision_id),
        .slot_state   (slot_state),
        .references   (references)
    );

    // clock
    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    // response of one slot, or zeros when nothing is addressed
    function automatic response_t slot_view(logic [2:0] st, int i, bit live);
        response_t r;
        r = '{status: st, idx: i[4:0], blk: '0, fid: '0, rid: '0, phase: '0, refs: '0};
        if (live)
        begin
            r.blk   = tbl_blk[i];
            r.fid   = tbl_file[i];
            r.rid   = tbl_rev[i];
            r.phase = tbl_phase[i];
            r.refs  = tbl_refs[i][7:0];
        end
        return r;
    endfunction

    // apply one request to the shadow table and return the response
    function automatic response_t table_update(request_t q);
        logic [9:0] b;
        int         best;
        int         s;
        b    = 10'(q.boff >> BSHIFT);
        best = -1;
        s    = q.slot;
        if (q.kind == K_SCHED)
        begin
            for (int i = 0; i < NSLOT; i++)
            begin
                if (tbl_valid[i] && tbl_file[i] == q.fkey && tbl_rev[i] == q.rkey
                    && tbl_blk[i] == b)
                begin
                    tbl_stamp[i] = q.stamp;
                    if (tbl_refs[i] < REF_TOP)
                        tbl_refs[i]++;
                    return slot_view(ST_HIT, i, 1'b1);
                end
            end
            for (int i = 0; i < NSLOT; i++)
                if (tbl_refs[i] == 0 && (best < 0 || tbl_stamp[i] < tbl_stamp[best]))
                    best = i;
            if (best < 0)
                return slot_view(ST_NOFREE, 0, 1'b0);
            tbl_valid[best] = 1'b1;
            tbl_file[best]  = q.fkey;
            tbl_rev[best]   = q.rkey;
            tbl_blk[best]   = b;
            tbl_phase[best] = PH_SCHED;
            tbl_stamp[best] = q.stamp;
            tbl_refs[best]  = 1;
            return slot_view(ST_ALLOC, best, 1'b1);
        end
        if (q.kind == K_PICK)
        begin
            for (int i = 0; i < NSLOT; i++)
                if (tbl_valid[i] && tbl_phase[i] == PH_SCHED && (best < 0
                    || tbl_refs[i] > tbl_refs[best]
                    || (tbl_refs[i] == tbl_refs[best] && tbl_blk[i] < tbl_blk[best])))
                    best = i;
            if (best < 0)
                return slot_view(ST_NOSCHED, 0, 1'b0);
            tbl_phase[best] = PH_DOWN;
            if (tbl_refs[best] < REF_TOP)
                tbl_refs[best]++;
            return slot_view(ST_PICKED, best, 1'b1);
        end
        if (q.kind == K_RELEASE || q.kind == K_DONE)
        begin
            if (tbl_refs[s] == 0)
                return slot_view(ST_UNDER, s, 1'b1);
            if (q.kind == K_DONE)
                tbl_phase[s] = q.succ ? PH_DONE : PH_SCHED;
            tbl_refs[s]--;
            return slot_view(ST_OK, s, 1'b1);
        end
        return slot_view(ST_OK, s, 1'b1);
    endfunction

    // a slot that has been allocated at least once
    function automatic logic [4:0] written_slot();
        int cand [$];
        for (int i = 0; i < NSLOT; i++)
            if (tbl_valid[i])
                cand.push_back(i);
        return 5'(cand[$urandom_range(0, cand.size() - 1)]);
    endfunction

    task automatic issue(request_t q);
        pending_reqs.push_back(q);
        expected_rsps.push_back(table_update(q));
    endtask

    // random request, mostly drawn from small key and block pools
    function automatic request_t random_request();
        request_t q;
        int       pick;
        bit       any_valid;
        any_valid = 1'b0;
        for (int i = 0; i < NSLOT; i++)
            any_valid |= tbl_valid[i];
        clock_now += $urandom_range(0, 3);
        q.fkey  = ($urandom_range(0, 9) == 0) ? $urandom() : key_pool[$urandom_range(0, 3)];
        q.rkey  = ($urandom_range(0, 9) == 0) ? $urandom() : key_pool[$urandom_range(0, 1)];
        q.boff  = {$urandom_range(0, 5), 22'h0} | ($urandom() & 32'h003f_ffff);
        if ($urandom_range(0, 9) == 0)
            q.boff = $urandom();
        q.slot  = any_valid ? written_slot() : 5'd0;
        q.succ  = $urandom_range(0, 1);
        q.stamp = ($urandom_range(0, 19) == 0) ? $urandom() : clock_now;
        pick    = $urandom_range(0, 99);
        if (!any_valid || pick < 35)
            q.kind = K_SCHED;
        else if (pick < 50)
            q.kind = K_PICK;
        else if (pick < 70)
            q.kind = K_DONE;
        else if (pick < 88)
            q.kind = K_RELEASE;
        else if (pick < 95)
            q.kind = K_QUERY;
        else
            q.kind = $urandom_range(5, 7);
        return q;
    endfunction

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    task automatic drain();
        while (pending_reqs.size() != 0 || expected_rsps.size() != 0)
            @(posedge clk);
    endtask

    // driver: present the next request at the falling edge
    always @(negedge clk)
    begin
        bit fresh;
        fresh = 1'b0;
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else
        begin
            if (took)
            begin
                void'(pending_reqs.pop_front());
                took  = 1'b0;
                fresh = 1'b1;
            end
            if (pending_reqs.size() != 0
                && ((start && !fresh) || $urandom_range(0, 99) >= idle_pct))
            begin
                start        <= 1'b1;
                kind         <= pending_reqs[0].kind;
                file_key     <= pending_reqs[0].fkey;
                revision_key <= pending_reqs[0].rkey;
                byte_offset  <= pending_reqs[0].boff;
                slot         <= pending_reqs[0].slot;
                success      <= pending_reqs[0].succ;
                now          <= pending_reqs[0].stamp;
            end
            else
            begin
                start <= 1'b0;
            end
        end
    end

    // monitor: acceptance and response checking
    always @(posedge clk)
    begin
        response_t e;
        if (rst_n && start && !busy)
            took = 1'b1;
        if (rst_n && done)
        begin
            if (expected_rsps.size() == 0)
            begin
                $display("unexpected response at %0t", $realtime);
                errors++;
            end
            else
            begin
                e = expected_rsps.pop_front();
                if (status !== e.status)         report("status", status, e.status);
                if (slot_index !== e.idx)        report("slot_index", slot_index, e.idx);
                if (block_number !== e.blk)      report("block_number", block_number, e.blk);
                if (file_id !== e.fid)           report("file_id", file_id, e.fid);
                if (revision_id !== e.rid)       report("revision_id", revision_id, e.rid);
                if (slot_state !== e.phase)      report("slot_state", slot_state, e.phase);
                if (references !== e.refs)       report("references", references, e.refs);
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_MAX)
        begin
            $display("tb_refcounted_block_cache_scheduler NOT OK");
            $finish;
        end
    end

    // stimulus
    initial
    begin
        request_t q;
        int       phase_pct [4];
        errors       = 0;
        cycles       = 0;
        took         = 1'b0;
        idle_pct     = 0;
        clock_now    = 32'd10;
        rst_n        = 1'b0;
        start        = 1'b0;
        kind         = K_QUERY;
        file_key     = '0;
        revision_key = '0;
        byte_offset  = '0;
        slot         = '0;
        success      = 1'b0;
        now          = '0;
        phase_pct    = '{0, 68, 9, 0};
        key_pool     = '{32'h0, 32'hffff_ffff, $urandom(), $urandom()};
        for (int i = 0; i < NSLOT; i++)
        begin
            tbl_valid[i] = 1'b0;
            tbl_file[i]  = '0;
            tbl_rev[i]   = '0;
            tbl_blk[i]   = '0;
            tbl_refs[i]  = 0;
            tbl_phase[i] = PH_CLEAN;
            tbl_stamp[i] = '0;
        end
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: empty pick, field extremes, every kind, underflow
        q = '{K_PICK, 32'h0, 32'h0, 32'h0, 5'd0, 1'b0, 32'h0};
        issue(q);
        q = '{K_SCHED, 32'h0, 32'h0, 32'h0, 5'd0, 1'b0, 32'h0};
        issue(q);
        q = '{K_SCHED, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 5'd31, 1'b1, 32'hffff_ffff};
        issue(q);
        q = '{K_SCHED, 32'h0, 32'h0, 32'h003f_ffff, 5'd0, 1'b0, 32'd5};
        issue(q);
        q.kind = K_PICK;
        issue(q);
        issue(q);
        issue(q);
        q = '{K_DONE, 32'h0, 32'h0, 32'h0, 5'd0, 1'b1, 32'd6};
        issue(q);
        q.slot = 5'd1;
        q.succ = 1'b0;
        issue(q);
        for (int k = 0; k < 4; k++)
        begin
            q.kind = K_RELEASE;
            q.slot = 5'd0;
            issue(q);
        end
        for (int k = K_QUERY; k <= 7; k++)
        begin
            q.kind = k[2:0];
            q.slot = 5'd1;
            issue(q);
        end

        // fill every slot until no free slot is left, then release them all
        for (int k = 0; k < NSLOT + 1; k++)
        begin
            clock_now += 1;
            q = '{K_SCHED, $urandom(), $urandom(), $urandom(), 5'd0, 1'b0, clock_now};
            issue(q);
        end
        for (int i = 0; i < NSLOT; i++)
            while (tbl_refs[i] != 0)
                issue('{K_RELEASE, 32'h0, 32'h0, 32'h0, i[4:0], 1'b0, clock_now});

        // reference saturation: repeated hits on one block
        q = '{K_SCHED, key_pool[2], key_pool[3], 32'h0040_0000, 5'd0, 1'b0, clock_now};
        for (int k = 0; k < REF_TOP + 3; k++)
            issue(q);
        drain();

        // random part across idle phases
        for (int p = 0; p < 4; p++)
        begin
            idle_pct = phase_pct[p];
            for (int k = 0; k < 27; k++)
                issue(random_request());
            drain();
        end

        repeat (60) @(posedge clk);
        if (errors == 0)
        begin
            $display("tb_refcounted_block_cache_scheduler OK");
        end
        else
        begin
            $display("tb_refcounted_block_cache_scheduler NOT OK");
        end
        $finish;
    end

endmodule
